// ===== hw/rtl/shc_pkg.sv =====
// Shared types, codes and helpers for the spa heater safety controller.
// No dependencies; used by shc_step and spa_heater_safety_controller.
`default_nettype none

package shc_pkg;

    // Default phase lengths in seconds
    localparam int unsigned PurgeSecondsDef    = 10;
    localparam int unsigned CooldownSecondsDef = 30;

    // Temperature limits, tenths of a degree F
    localparam logic signed [12:0] OvertempLimit = 13'sd1045;
    localparam logic signed [12:0] FreezeLimit   = 13'sd440;
    localparam logic signed [12:0] SleepDrop     = 13'sd200;
    localparam logic signed [12:0] Hysteresis    = 13'sd5;
    localparam logic [10:0]        SetpointMin   = 11'd800;
    localparam logic [10:0]        SetpointMax   = 11'd1040;
    localparam logic [10:0]        SetpointRst   = 11'd1000;
    localparam logic [7:0]         TimeoutRst    = 8'd15;

    // Input op codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_JET1   = 3'd1;
    localparam logic [2:0] OP_JET2   = 3'd2;
    localparam logic [2:0] OP_BLOWER = 3'd3;
    localparam logic [2:0] OP_LIGHT  = 3'd4;

    // Heat modes
    localparam logic [1:0] HM_STANDARD = 2'd0;
    localparam logic [1:0] HM_ECONOMY  = 2'd1;
    localparam logic [1:0] HM_SLEEP    = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_HEAT_SEL = 2'd1;
    localparam logic [1:0] REG_JET_TMO  = 2'd2;
    localparam logic [1:0] REG_BLOW_TMO = 2'd3;

    // Reported mode codes
    localparam logic [2:0] MC_STANDBY  = 3'd0;
    localparam logic [2:0] MC_FILTER   = 3'd1;
    localparam logic [2:0] MC_PURGE    = 3'd2;
    localparam logic [2:0] MC_HEAT     = 3'd3;
    localparam logic [2:0] MC_COOL     = 3'd4;
    localparam logic [2:0] MC_FLOWERR  = 3'd5;
    localparam logic [2:0] MC_FREEZE   = 3'd6;
    localparam logic [2:0] MC_OVERTEMP = 3'd7;

    typedef enum logic [7:0] {
        M_STANDBY  = 8'b0000_0001,
        M_FILTER   = 8'b0000_0010,
        M_PURGE    = 8'b0000_0100,
        M_HEAT     = 8'b0000_1000,
        M_COOL     = 8'b0001_0000,
        M_FLOWERR  = 8'b0010_0000,
        M_FREEZE   = 8'b0100_0000,
        M_OVERTEMP = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic        heater;
        logic        pump;
        logic        ozone;
        logic        jet1;
        logic        jet2;
        logic        blower;
        logic        light;
        logic [13:0] jet1_left;
        logic [13:0] jet2_left;
        logic [13:0] blower_left;
        logic [3:0]  purge_left;
        logic [4:0]  cool_left;
    } t_state;

    typedef struct packed {
        logic [10:0] setpoint;
        logic [1:0]  heat_sel;
        logic [7:0]  jet_min;
        logic [7:0]  blower_min;
    } t_cfg;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            M_STANDBY:  c = MC_STANDBY;
            M_FILTER:   c = MC_FILTER;
            M_PURGE:    c = MC_PURGE;
            M_HEAT:     c = MC_HEAT;
            M_COOL:     c = MC_COOL;
            M_FLOWERR:  c = MC_FLOWERR;
            M_FREEZE:   c = MC_FREEZE;
            M_OVERTEMP: c = MC_OVERTEMP;
            default:    c = MC_STANDBY;
        endcase
        return c;
    endfunction

    // minutes * 60 as (m << 6) - (m << 2)
    function automatic logic [13:0] min_to_sec(input logic [7:0] m);
        logic [13:0] w;
        w = {6'd0, m};
        return (w << 6) - (w << 2);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spa_heater_safety_controller.sv =====
// Top level: config registers, controller state and result handshake.
// Depends on shc_pkg and shc_step.
`default_nettype none

// Channel   Direction  Handshake                      Payload
// in        request    i_in_valid / o_in_ready        op, temp, flow, high limit, filter
// out       result     o_out_valid / i_out_ready      mode, relays, timers, phase
// config    write/read psel penable pwrite pready     paddr[3:2] index, pwdata/prdata
//
// One request per cycle unless the result stalls: the step logic runs between the state
// registers and the result is the registered state, valid in the cycle after acceptance.
// The state registers double as the result register; a new request is taken
// whenever the result is empty or being taken in the same cycle.
// A stalled result holds, and so does the input side.
// Reset (i_rst_n low, synchronous) gives standby, all relays off, timers zero,
// and config defaults (setpoint 100.0 F, standard mode, 15 minute timeouts).

module spa_heater_safety_controller #(
    parameter int unsigned PURGE_SECONDS    = shc_pkg::PurgeSecondsDef,
    parameter int unsigned COOLDOWN_SECONDS = shc_pkg::CooldownSecondsDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [12:0] i_temp_tenths_f,
    input  wire logic               i_flow_ok,
    input  wire logic               i_high_limit_trip,
    input  wire logic               i_filter_window,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_mode_code,
    output logic                    o_heater_on,
    output logic                    o_pump_on,
    output logic                    o_ozone_on,
    output logic                    o_jet1_on,
    output logic                    o_jet2_on,
    output logic                    o_blower_on,
    output logic                    o_light_on,
    output logic [13:0]             o_jet1_seconds,
    output logic [13:0]             o_jet2_seconds,
    output logic [13:0]             o_blower_seconds,
    output logic [4:0]              o_phase_seconds
);

    shc_pkg::t_cfg   r_cfg;
    shc_pkg::t_state r_state;
    shc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            cfg_wr;
    logic            in_acc;
    logic [10:0]     sp_clamped;

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        priority if (pwdata[10:0] < shc_pkg::SetpointMin) sp_clamped = shc_pkg::SetpointMin;
        else if (pwdata[10:0] > shc_pkg::SetpointMax)     sp_clamped = shc_pkg::SetpointMax;
        else                                              sp_clamped = pwdata[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint   <= shc_pkg::SetpointRst;
            r_cfg.heat_sel   <= shc_pkg::HM_STANDARD;
            r_cfg.jet_min    <= shc_pkg::TimeoutRst;
            r_cfg.blower_min <= shc_pkg::TimeoutRst;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                shc_pkg::REG_SETPOINT: r_cfg.setpoint   <= sp_clamped;
                shc_pkg::REG_HEAT_SEL: r_cfg.heat_sel   <= pwdata[1:0];
                shc_pkg::REG_JET_TMO:  r_cfg.jet_min    <= pwdata[7:0];
                shc_pkg::REG_BLOW_TMO: r_cfg.blower_min <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            shc_pkg::REG_SETPOINT: prdata = {21'd0, r_cfg.setpoint};
            shc_pkg::REG_HEAT_SEL: prdata = {30'd0, r_cfg.heat_sel};
            shc_pkg::REG_JET_TMO:  prdata = {24'd0, r_cfg.jet_min};
            shc_pkg::REG_BLOW_TMO: prdata = {24'd0, r_cfg.blower_min};
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- step logic ----------------
    shc_step #(
        .PURGE_SECONDS    (PURGE_SECONDS),
        .COOLDOWN_SECONDS (COOLDOWN_SECONDS)
    ) u_step (
        .i_cur  (r_state),
        .i_cfg  (r_cfg),
        .i_op   (i_op),
        .i_temp (i_temp_tenths_f),
        .i_flow (i_flow_ok),
        .i_trip (i_high_limit_trip),
        .i_filt (i_filter_window),
        .o_nxt  (n_state)
    );

    // Result slot empty or draining this cycle -> take the next request
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{mode: shc_pkg::M_STANDBY, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- result fields ----------------
    assign o_out_valid      = r_out_valid;
    assign o_mode_code      = shc_pkg::mode_code(r_state.mode);
    assign o_heater_on      = r_state.heater;
    assign o_pump_on        = r_state.pump;
    assign o_ozone_on       = r_state.ozone;
    assign o_jet1_on        = r_state.jet1;
    assign o_jet2_on        = r_state.jet2;
    assign o_blower_on      = r_state.blower;
    assign o_light_on       = r_state.light;
    assign o_jet1_seconds   = r_state.jet1_left;
    assign o_jet2_seconds   = r_state.jet2_left;
    assign o_blower_seconds = r_state.blower_left;

    // phase shows purge count in purge, cooldown count in cooldown, else zero
    always_comb begin
        unique case (r_state.mode)
            shc_pkg::M_PURGE: o_phase_seconds = {1'b0, r_state.purge_left};
            shc_pkg::M_COOL:  o_phase_seconds = r_state.cool_left;
            default:          o_phase_seconds = 5'd0;
        endcase
    end

    // ---------------- assertions ----------------
    a_heater_needs_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_heater_on |-> o_pump_on)
        else $error("heater on without pump");

    a_overtemp_heater_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mode_code == shc_pkg::MC_OVERTEMP) |-> !o_heater_on)
        else $error("heater on in overtemp");

    a_jet1_off_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_jet1_on |-> (o_jet1_seconds == 14'd0))
        else $error("jet1 timer running while off");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken over a stalled result");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

endmodule

`default_nettype wire

// ===== hw/rtl/shc_step.sv =====
// Next-state logic for one request: tick or accessory toggle.
// Depends on shc_pkg (state, config types, codes).
`default_nettype none

module shc_step #(
    parameter int unsigned PURGE_SECONDS    = shc_pkg::PurgeSecondsDef,
    parameter int unsigned COOLDOWN_SECONDS = shc_pkg::CooldownSecondsDef
) (
    input  wire shc_pkg::t_state    i_cur,
    input  wire shc_pkg::t_cfg      i_cfg,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [12:0] i_temp,
    input  wire logic               i_flow,
    input  wire logic               i_trip,
    input  wire logic               i_filt,
    output shc_pkg::t_state         o_nxt
);

    logic signed [12:0] thr;
    logic               demand;
    logic [13:0]        jet_sec;
    logic [13:0]        blow_sec;

    always_comb begin
        thr = $signed({2'b00, i_cfg.setpoint})
            - ((i_cfg.heat_sel == shc_pkg::HM_SLEEP) ? shc_pkg::SleepDrop : 13'sd0)
            - shc_pkg::Hysteresis;
        demand = (i_temp < thr) && !((i_cfg.heat_sel == shc_pkg::HM_ECONOMY) && !i_filt);
        jet_sec  = shc_pkg::min_to_sec(i_cfg.jet_min);
        blow_sec = shc_pkg::min_to_sec(i_cfg.blower_min);
    end

    always_comb begin
        o_nxt = i_cur;
        unique case (i_op)
            shc_pkg::OP_TICK: begin
                if (i_temp >= shc_pkg::OvertempLimit || i_trip) begin
                    o_nxt.heater = 1'b0;
                    o_nxt.mode   = shc_pkg::M_OVERTEMP;
                end else if (i_temp <= shc_pkg::FreezeLimit) begin
                    o_nxt.mode   = shc_pkg::M_FREEZE;
                    o_nxt.pump   = 1'b1;
                    o_nxt.heater = i_flow;
                end else begin
                    // auto-off timers
                    if (i_cur.jet1) begin
                        if (i_cur.jet1_left != '0) o_nxt.jet1_left = i_cur.jet1_left - 14'd1;
                        else                       o_nxt.jet1 = 1'b0;
                    end
                    if (i_cur.jet2) begin
                        if (i_cur.jet2_left != '0) o_nxt.jet2_left = i_cur.jet2_left - 14'd1;
                        else                       o_nxt.jet2 = 1'b0;
                    end
                    if (i_cur.blower) begin
                        if (i_cur.blower_left != '0) o_nxt.blower_left = i_cur.blower_left - 14'd1;
                        else                         o_nxt.blower = 1'b0;
                    end
                    o_nxt.ozone = i_filt;

                    unique case (i_cur.mode)
                        shc_pkg::M_STANDBY, shc_pkg::M_FREEZE: begin
                            if (demand) begin
                                o_nxt.mode       = shc_pkg::M_PURGE;
                                o_nxt.purge_left = 4'(PURGE_SECONDS);
                                o_nxt.pump       = 1'b1;
                            end else if (i_filt) begin
                                o_nxt.mode = shc_pkg::M_FILTER;
                                o_nxt.pump = 1'b1;
                            end else begin
                                o_nxt.pump   = 1'b0;
                                o_nxt.heater = 1'b0;
                            end
                        end
                        shc_pkg::M_PURGE: begin
                            o_nxt.pump = 1'b1;
                            if (!i_flow) begin
                                o_nxt.mode   = shc_pkg::M_FLOWERR;
                                o_nxt.heater = 1'b0;
                            end else if (i_cur.purge_left != '0) begin
                                o_nxt.purge_left = i_cur.purge_left - 4'd1;
                            end else begin
                                o_nxt.mode   = shc_pkg::M_HEAT;
                                o_nxt.heater = 1'b1;
                            end
                        end
                        shc_pkg::M_HEAT: begin
                            if (!i_flow) begin
                                o_nxt.mode   = shc_pkg::M_FLOWERR;
                                o_nxt.heater = 1'b0;
                            end else if (!demand) begin
                                o_nxt.mode      = shc_pkg::M_COOL;
                                o_nxt.cool_left = 5'(COOLDOWN_SECONDS);
                                o_nxt.heater    = 1'b0;
                            end else begin
                                o_nxt.pump   = 1'b1;
                                o_nxt.heater = 1'b1;
                            end
                        end
                        shc_pkg::M_COOL: begin
                            o_nxt.heater = 1'b0;
                            o_nxt.pump   = 1'b1;
                            if (i_cur.cool_left != '0) o_nxt.cool_left = i_cur.cool_left - 5'd1;
                            else                       o_nxt.mode = shc_pkg::M_STANDBY;
                        end
                        shc_pkg::M_FILTER: begin
                            o_nxt.pump = 1'b1;
                            if (demand) begin
                                o_nxt.mode       = shc_pkg::M_PURGE;
                                o_nxt.purge_left = 4'(PURGE_SECONDS);
                            end else if (!i_filt) begin
                                o_nxt.mode = shc_pkg::M_STANDBY;
                            end
                        end
                        shc_pkg::M_FLOWERR: begin
                            o_nxt.heater = 1'b0;
                            if (i_flow) o_nxt.mode = shc_pkg::M_STANDBY;
                        end
                        default: begin
                            // overtemp latch: state machine holds
                        end
                    endcase
                end
            end
            shc_pkg::OP_JET1: begin
                o_nxt.jet1      = !i_cur.jet1;
                o_nxt.jet1_left = i_cur.jet1 ? 14'd0 : jet_sec;
            end
            shc_pkg::OP_JET2: begin
                o_nxt.jet2      = !i_cur.jet2;
                o_nxt.jet2_left = i_cur.jet2 ? 14'd0 : jet_sec;
            end
            shc_pkg::OP_BLOWER: begin
                o_nxt.blower      = !i_cur.blower;
                o_nxt.blower_left = i_cur.blower ? 14'd0 : blow_sec;
            end
            shc_pkg::OP_LIGHT: begin
                o_nxt.light = !i_cur.light;
            end
            default: begin
                // unused op: report state unchanged
            end
        endcase
    end

endmodule

`default_nettype wire
